@@ src/bgc_pkg.sv @@
// bgc_pkg: shared types, widths and grid mask functions for bitboard_group_count
// used by bgc_grow and bitboard_group_count; no dependencies
package bgc_pkg;

    localparam int OCC_W   = 64;
    localparam int COUNT_W = 5;
    localparam int MAX_SIDE = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_GROW,
        ST_DONE
    } bgc_state_t;

    // squares that lie inside a side by side grid
    function automatic logic [OCC_W-1:0] grid_mask_f(input int side);
        logic [OCC_W-1:0] m;
        m = '0;
        for (int i = 0; i < OCC_W; i++)
        begin
            if (i < side * side)
                m[i] = 1'b1;
        end
        return m;
    endfunction

    // squares of one column of a side by side grid
    function automatic logic [OCC_W-1:0] col_mask_f(input int side, input int col);
        logic [OCC_W-1:0] m;
        int               idx;
        m = '0;
        for (int r = 0; r < MAX_SIDE; r++)
        begin
            idx = r * side + col;
            if (r < side && idx < OCC_W)
                m[idx] = 1'b1;
        end
        return m;
    endfunction

endpackage

@@ src/bitboard_group_count.sv @@
// bitboard_group_count: counts 8-connected groups of occupied squares on a grid
// sequence: each group is seeded from the lowest remaining square, grown until it stops changing,
// then removed from the remaining squares and counted; one dilation step per cycle while growing
// one transaction at a time: the next one is accepted in the idle state, after the result registers
// reset: asynchronous active low, clears the sequencer and the output valid flag
// depends on bgc_pkg and bgc_grow
module bitboard_group_count
    import bgc_pkg::*;
#(
    parameter int GRID_SIDE = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [OCC_W-1:0]   occupancy,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [COUNT_W-1:0] group_count
);

    localparam logic [OCC_W-1:0] GRID_MASK = grid_mask_f(GRID_SIDE);

    bgc_state_t         state_reg, state_next;
    logic [OCC_W-1:0]   left_reg, left_next;
    logic [OCC_W-1:0]   region_reg, region_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] result_reg, result_next;

    logic [OCC_W-1:0]   lowest;
    logic [OCC_W-1:0]   grown;
    logic               changed;
    logic               out_free;

    bgc_grow #(
        .GRID_SIDE (GRID_SIDE)
    ) u_grow (
        .region  (region_reg),
        .left    (left_reg),
        .grown   (grown),
        .changed (changed)
    );

    assign lowest   = left_reg & (~left_reg + {{(OCC_W-1){1'b0}}, 1'b1});
    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_SEED;
            end
            ST_SEED:
            begin
                if (left_reg == '0)
                    state_next = ST_DONE;
                else
                    state_next = ST_GROW;
            end
            ST_GROW:
            begin
                if (!changed)
                    state_next = ST_SEED;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        in_ready       = 1'b0;
        left_next      = left_reg;
        region_next    = region_reg;
        count_next     = count_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    left_next  = occupancy & GRID_MASK;
                    count_next = '0;
                end
            end
            ST_SEED:
            begin
                region_next = lowest;
            end
            ST_GROW:
            begin
                if (changed)
                    region_next = grown;
                else
                begin
                    left_next  = left_reg & ~region_reg;
                    count_next = count_reg + {{(COUNT_W-1){1'b0}}, 1'b1};
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    result_next    = count_reg;
                    out_valid_next = 1'b1;
                end
            end
            default: in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg   <= left_next;
        region_reg <= region_next;
        count_reg  <= count_next;
        result_reg <= result_next;
    end

    assign out_valid   = out_valid_reg;
    assign group_count = result_reg;

    // a new result only comes out of the done state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result appeared outside done state");

    // the growing region never leaves the remaining squares
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GROW) |-> ((region_reg & ~left_reg) == '0))
        else $error("region outside remaining squares");

    // a growing region always holds its seed
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GROW) |-> (region_reg != '0))
        else $error("empty region while growing");

    // an accepted transaction starts the first seed step
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_SEED))
        else $error("accepted transaction did not start seeding");

endmodule

@@ src/bgc_grow.sv @@
// bgc_grow: one-step eight-direction dilation unit, no wrap across edges
// masked by the remaining squares; depends on bgc_pkg
module bgc_grow
    import bgc_pkg::*;
#(
    parameter int GRID_SIDE = 8
)
(
    input  logic [OCC_W-1:0] region,
    input  logic [OCC_W-1:0] left,
    output logic [OCC_W-1:0] grown,
    output logic             changed
);

    localparam int               S         = GRID_SIDE;
    localparam logic [OCC_W-1:0] GRID_MASK = grid_mask_f(GRID_SIDE);
    localparam logic [OCC_W-1:0] NO_LEFT   = GRID_MASK & ~col_mask_f(GRID_SIDE, 0);
    localparam logic [OCC_W-1:0] NO_RIGHT  = GRID_MASK & ~col_mask_f(GRID_SIDE, GRID_SIDE - 1);

    logic [OCC_W-1:0] to_lower;
    logic [OCC_W-1:0] to_higher;
    logic [OCC_W-1:0] spread;

    always_comb
    begin
        to_lower  = region & NO_LEFT;
        to_higher = region & NO_RIGHT;
        spread    = (to_higher << 1) | (to_lower >> 1)
                  | (region << S) | (region >> S)
                  | (to_higher << (S + 1)) | (to_lower << (S - 1))
                  | (to_higher >> (S - 1)) | (to_lower >> (S + 1));
        grown     = (region | (spread & GRID_MASK)) & left;
        changed   = (grown != region);
    end

endmodule
